>>> rtl/drtd_pkg.sv
// Shared types and constants of the relocation table decoder.
`timescale 1ns / 1ps
`default_nettype none
package drtd_pkg;

   // Image memory geometry
   localparam int IMAGE_BYTES = 65536;
   localparam int IMG_AW      = $clog2(IMAGE_BYTES);
   localparam int IMG_SIZE_W  = 21;
   localparam logic [IMG_SIZE_W-1:0] IMG_LIM        = IMG_SIZE_W'(IMAGE_BYTES);
   localparam logic [IMG_SIZE_W-1:0] IMAGE_SIZE_RST = 21'd65536;

   // Command queue between front and back
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PW    = $clog2(CMD_DEPTH);
   localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);

   // Request function codes
   localparam logic [1:0] FUNC_LOAD    = 2'd0;
   localparam logic [1:0] FUNC_DECODE  = 2'd1;
   localparam logic [1:0] FUNC_RESTART = 2'd2;

   // Decoding constants
   localparam logic [7:0]  FAR_CALL_OP = 8'h9a;
   localparam logic [7:0]  SKIP_STEP   = 8'd254;
   localparam logic [7:0]  CODE_SEARCH = 8'd0;
   localparam logic [7:0]  CODE_SKIP   = 8'd1;
   localparam logic [16:0] OFS_LIMIT   = 17'h10000;
   localparam logic [2:0]  WIN_FULL    = 3'd5;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_DECODE,
      CMD_RESTART
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [IMG_AW-1:0] addr;
      logic [7:0]        data;
   } cmd_type;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_GROUP,
      PH_CODES,
      PH_DONE
   } phase_type;

   typedef enum logic {
      ENG_CMD,
      ENG_SCAN
   } eng_type;

   typedef struct packed {
      logic        reloc_valid;
      logic [15:0] offset;
      logic [15:0] segment;
      logic        last;
      logic        error;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/drtd_front.sv
// Front end: accepts requests, classifies them and hands commands to the queue.
`timescale 1ns / 1ps
`default_nettype none
module drtd_front import drtd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [1:0]  req_func,
   input  wire logic [19:0] req_image_addr,
   input  wire logic [7:0]  req_data,
   output logic             cq_push,
   output cmd_type          cq_cmd,
   input  wire logic        cq_full
);

   logic    vld_ff, vld_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;
   logic    keep;
   cmd_type cls;

   assign full    = vld_ff && cq_full;
   assign accept  = push && !full;
   assign cq_push = vld_ff && !cq_full;
   assign cq_cmd  = cmd_ff;

   // Drop unused selectors and image writes beyond the memory
   always_comb begin
      cls.addr = req_image_addr[IMG_AW-1:0];
      cls.data = req_data;
      cls.kind = CMD_LOAD;
      keep     = 1'b0;
      case (req_func)
         FUNC_LOAD: begin
            cls.kind = CMD_LOAD;
            keep     = ({1'b0, req_image_addr} < IMG_LIM);
         end
         FUNC_DECODE: begin
            cls.kind = CMD_DECODE;
            keep     = 1'b1;
         end
         FUNC_RESTART: begin
            cls.kind = CMD_RESTART;
            keep     = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   always_comb begin
      vld_in = vld_ff;
      cmd_in = cmd_ff;
      if (accept) begin
         vld_in = keep;
         cmd_in = cls;
      end else if (cq_push) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule
`default_nettype wire

>>> rtl/drtd_cmd_fifo.sv
// Short command queue that decouples the front end from the decode engine.
`timescale 1ns / 1ps
`default_nettype none
module drtd_cmd_fifo import drtd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic wr_en,
   input  wire cmd_type wr_cmd,
   output logic      q_full,
   input  wire logic rd_en,
   output cmd_type   rd_cmd,
   output logic      q_empty
);

   cmd_type           slot_ff [CMD_DEPTH];
   logic [CMD_PW-1:0] wp_ff, wp_in;
   logic [CMD_PW-1:0] rp_ff, rp_in;
   logic [CMD_CW-1:0] cnt_ff, cnt_in;
   logic              do_wr, do_rd;

   assign q_full  = (cnt_ff == CMD_CW'(CMD_DEPTH));
   assign q_empty = (cnt_ff == '0);
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_cmd  = slot_ff[rp_ff];

   always_comb begin
      wp_in  = do_wr ? CMD_PW'(wp_ff + 1'b1) : wp_ff;
      rp_in  = do_rd ? CMD_PW'(rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff;
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_wr) begin
         slot_ff[wp_ff] <= wr_cmd;
      end
   end

endmodule
`default_nettype wire

>>> rtl/drtd_back.sv
// Decode engine: image memory, table decoder, far-call scanner and result register.
`timescale 1ns / 1ps
`default_nettype none
module drtd_back import drtd_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [IMG_SIZE_W-1:0] csr_wr_data,
   input  wire cmd_type               q_head,
   input  wire logic                  q_empty,
   output logic                       q_pop,
   output logic                       empty,
   input  wire logic                  pop,
   output rsp_type                    rsp
);

   logic [7:0] img_mem [IMAGE_BYTES];
   logic [7:0] mem_rd_ff;
   logic       mem_we;

   eng_type         eng_ff, eng_in;
   phase_type       phase_ff, phase_in;
   logic [1:0]      hdr_ff, hdr_in;
   logic [7:0]      low_ff, low_in;
   logic [15:0]     ones_ff, ones_in;
   logic [15:0]     limit_ff, limit_in;
   logic [15:0]     seg_ff, seg_in;
   logic [16:0]     ofs_ff, ofs_in;
   logic            emit_ff, emit_in;
   logic [IMG_SIZE_W-1:0] isize_ff, isize_in;

   logic [IMG_SIZE_W-1:0] p_ff, p_in;
   logic [IMG_SIZE_W-1:0] pofs_ff, pofs_in;
   logic [IMG_SIZE_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic                  rdv_ff, rdv_in;
   logic [7:0]            win_ff [5];
   logic [7:0]            win_in [5];
   logic [2:0]            cnt_ff, cnt_in;

   logic    rsp_vld_ff, rsp_vld_in;
   rsp_type rsp_ff, rsp_in;

   logic [IMG_SIZE_W-1:0] lim;
   logic                  out_free;
   logic [15:0]           word;
   logic [7:0]            step;
   logic [17:0]           ofs_sum;
   logic [16:0]           ofs_sat;
   logic [15:0]           ones_dec;
   logic [IMG_SIZE_W-1:0] scan_start;
   logic [IMG_SIZE_W:0]   p_end;
   logic [IMG_SIZE_W:0]   hit_ofs;
   logic [16:0]           hit_sat;
   logic                  hit;

   assign empty = !rsp_vld_ff;
   assign rsp   = rsp_ff;

   assign lim      = (isize_ff > IMG_LIM) ? IMG_LIM : isize_ff;
   assign out_free = !rsp_vld_ff || pop;
   assign word     = {q_head.data, low_ff};

   // Offset step of a plain code byte, saturating at the group boundary
   assign step     = (q_head.data == CODE_SKIP) ? SKIP_STEP : q_head.data;
   assign ofs_sum  = {1'b0, ofs_ff} + {10'd0, step};
   assign ofs_sat  = (ofs_sum > {1'b0, OFS_LIMIT}) ? OFS_LIMIT : ofs_sum[16:0];
   assign ones_dec = ((ofs_sat < OFS_LIMIT) && (ones_ff != '0)) ? ones_ff - 1'b1 : ones_ff;

   assign scan_start = IMG_SIZE_W'({seg_ff, 4'd0}) + IMG_SIZE_W'(ofs_ff);

   // Scanner window check: opcode at p, segment word at p+3..p+4
   assign p_end   = {1'b0, p_ff} + (IMG_SIZE_W+1)'(4);
   assign hit     = (win_ff[0] == FAR_CALL_OP) && ({win_ff[4], win_ff[3]} <= limit_ff);
   assign hit_ofs = {1'b0, pofs_ff} + (IMG_SIZE_W+1)'(3);
   assign hit_sat = (hit_ofs > (IMG_SIZE_W+1)'(OFS_LIMIT)) ? OFS_LIMIT : hit_ofs[16:0];

   always_comb begin
      eng_in     = eng_ff;
      phase_in   = phase_ff;
      hdr_in     = hdr_ff;
      low_in     = low_ff;
      ones_in    = ones_ff;
      limit_in   = limit_ff;
      seg_in     = seg_ff;
      ofs_in     = ofs_ff;
      emit_in    = emit_ff;
      isize_in   = csr_wr_en ? csr_wr_data : isize_ff;
      p_in       = p_ff;
      pofs_in    = pofs_ff;
      rd_ptr_in  = IMG_SIZE_W'(rd_ptr_ff + 1'b1);
      rdv_in     = 1'b0;
      win_in     = win_ff;
      cnt_in     = cnt_ff;
      rsp_vld_in = rsp_vld_ff && !pop;
      rsp_in     = rsp_ff;
      q_pop      = 1'b0;
      mem_we     = 1'b0;

      case (eng_ff)
         ENG_CMD: begin
            if (!q_empty) begin
               case (q_head.kind)
                  CMD_LOAD: begin
                     mem_we = 1'b1;
                     q_pop  = 1'b1;
                  end
                  CMD_RESTART: begin
                     q_pop    = 1'b1;
                     phase_in = PH_HEADER;
                     hdr_in   = '0;
                     low_in   = '0;
                     ones_in  = '0;
                     limit_in = '0;
                     seg_in   = '0;
                     ofs_in   = '0;
                     emit_in  = 1'b1;
                  end
                  CMD_DECODE: begin
                     if (phase_ff == PH_DONE) begin
                        q_pop = 1'b1;
                     end else if (out_free) begin
                        q_pop  = 1'b1;
                        rsp_in = '0;
                        if (phase_ff == PH_HEADER || phase_ff == PH_GROUP) begin
                           rsp_vld_in = 1'b1;
                           hdr_in     = hdr_ff + 1'b1;
                           if (hdr_ff == 2'd0 || hdr_ff == 2'd2) begin
                              low_in = q_head.data;
                           end else if (phase_ff == PH_HEADER) begin
                              if (hdr_ff == 2'd1) begin
                                 ones_in = word;
                              end else begin
                                 limit_in = word;
                              end
                           end else begin
                              if (hdr_ff == 2'd1) begin
                                 ofs_in = {1'b0, word};
                              end else begin
                                 seg_in = seg_ff + word;
                              end
                           end
                           if (hdr_ff == 2'd3) begin
                              if (phase_ff == PH_HEADER) begin
                                 if (ones_ff == '0) begin
                                    phase_in    = PH_DONE;
                                    rsp_in.last = 1'b1;
                                 end else begin
                                    phase_in = PH_GROUP;
                                 end
                              end else begin
                                 phase_in = PH_CODES;
                                 emit_in  = 1'b1;
                              end
                           end
                        end else begin
                           rsp_in.reloc_valid = emit_ff;
                           rsp_in.offset      = emit_ff ? ofs_ff[15:0] : '0;
                           rsp_in.segment     = emit_ff ? seg_ff : '0;
                           emit_in            = 1'b1;
                           if (q_head.data == CODE_SEARCH) begin
                              // Start the walk; result leaves when the walk ends
                              eng_in     = ENG_SCAN;
                              p_in       = scan_start;
                              pofs_in    = IMG_SIZE_W'(ofs_ff);
                              rd_ptr_in  = scan_start;
                              cnt_in     = '0;
                           end else begin
                              rsp_vld_in = 1'b1;
                              ofs_in     = ofs_sat;
                              if (q_head.data == CODE_SKIP) begin
                                 ones_in = ones_dec;
                                 emit_in = 1'b0;
                              end
                              if ((q_head.data == CODE_SKIP) && (ones_dec == '0)) begin
                                 phase_in    = PH_DONE;
                                 rsp_in.last = 1'b1;
                              end else if ((q_head.data != CODE_SKIP) && (ones_ff == '0)) begin
                                 phase_in    = PH_DONE;
                                 rsp_in.last = 1'b1;
                              end else if (ofs_sat >= OFS_LIMIT) begin
                                 phase_in = PH_GROUP;
                                 hdr_in   = '0;
                              end
                           end
                        end
                     end
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         ENG_SCAN: begin
            rdv_in = 1'b1;
            if (cnt_ff == WIN_FULL) begin
               if (p_end >= {1'b0, lim}) begin
                  // Ran out of loaded image
                  eng_in        = ENG_CMD;
                  rdv_in        = 1'b0;
                  phase_in      = PH_DONE;
                  rsp_vld_in    = 1'b1;
                  rsp_in.error  = 1'b1;
               end else if (hit) begin
                  eng_in     = ENG_CMD;
                  rdv_in     = 1'b0;
                  ofs_in     = hit_sat;
                  rsp_vld_in = 1'b1;
                  if (ones_ff == '0) begin
                     phase_in    = PH_DONE;
                     rsp_in.last = 1'b1;
                  end else if (hit_sat >= OFS_LIMIT) begin
                     phase_in = PH_GROUP;
                     hdr_in   = '0;
                  end
               end else begin
                  p_in    = IMG_SIZE_W'(p_ff + 1'b1);
                  pofs_in = IMG_SIZE_W'(pofs_ff + 1'b1);
               end
            end
            if (rdv_ff && !((cnt_ff == WIN_FULL) && (eng_in == ENG_CMD))) begin
               win_in[0] = win_ff[1];
               win_in[1] = win_ff[2];
               win_in[2] = win_ff[3];
               win_in[3] = win_ff[4];
               win_in[4] = mem_rd_ff;
               if (cnt_ff != WIN_FULL) begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            eng_in = ENG_CMD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         img_mem[q_head.addr] <= q_head.data;
      end
      mem_rd_ff <= img_mem[rd_ptr_ff[IMG_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eng_ff     <= ENG_CMD;
         phase_ff   <= PH_HEADER;
         hdr_ff     <= '0;
         low_ff     <= '0;
         ones_ff    <= '0;
         limit_ff   <= '0;
         seg_ff     <= '0;
         ofs_ff     <= '0;
         emit_ff    <= 1'b1;
         isize_ff   <= IMAGE_SIZE_RST;
         rdv_ff     <= 1'b0;
         cnt_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         eng_ff     <= eng_in;
         phase_ff   <= phase_in;
         hdr_ff     <= hdr_in;
         low_ff     <= low_in;
         ones_ff    <= ones_in;
         limit_ff   <= limit_in;
         seg_ff     <= seg_in;
         ofs_ff     <= ofs_in;
         emit_ff    <= emit_in;
         isize_ff   <= isize_in;
         rdv_ff     <= rdv_in;
         cnt_ff     <= cnt_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      p_ff       <= p_in;
      pofs_ff    <= pofs_in;
      rd_ptr_ff  <= rd_ptr_in;
      win_ff     <= win_in;
      rsp_ff     <= rsp_in;
   end

endmodule
`default_nettype wire

>>> rtl/dos_reloc_table_decoder_unit.sv
// Top level of the relocation table decoder: front end, command queue and decode engine.
// Path: an accepted request passes the front register and a queue slot; the engine then
//   writes its result into the result register, which holds it on the ports.
// Throughput: one request per cycle while the queue has room; a search code holds the engine
//   while it reads the image, fills the five-byte window, then checks the positions in turn.
// Reset: synchronous, active high; clears queue, decode state, result; image length 65536.
`timescale 1ns / 1ps
`default_nettype none
module dos_reloc_table_decoder_unit import drtd_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  push,
   output logic                       full,
   input  wire logic [1:0]            req_func,
   input  wire logic [19:0]           req_image_addr,
   input  wire logic [7:0]            req_data,
   // result channel
   output logic                       empty,
   input  wire logic                  pop,
   output logic                       rsp_reloc_valid,
   output logic [15:0]                rsp_offset,
   output logic [15:0]                rsp_segment,
   output logic                       rsp_last,
   output logic                       rsp_error,
   // image length register
   input  wire logic                  csr_wr_en,
   input  wire logic [IMG_SIZE_W-1:0] csr_wr_data
);

   logic    cq_push;
   cmd_type cq_cmd;
   logic    cq_full;
   cmd_type q_head;
   logic    q_empty;
   logic    q_pop;
   rsp_type rsp;

   // Front end: classify each request, drop unused selectors and
   // image writes outside the memory, hold one command for the queue
   drtd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_func       (req_func),
      .req_image_addr (req_image_addr),
      .req_data       (req_data),
      .cq_push        (cq_push),
      .cq_cmd         (cq_cmd),
      .cq_full        (cq_full)
   );

   // Queue: keeps requests flowing in while the engine walks the image
   drtd_cmd_fifo u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cq_push),
      .wr_cmd  (cq_cmd),
      .q_full  (cq_full),
      .rd_en   (q_pop),
      .rd_cmd  (q_head),
      .q_empty (q_empty)
   );

   // Engine: commands are carried out strictly in arrival order, so image
   // loads always land before the table bytes that search them
   drtd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_head      (q_head),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .empty       (empty),
      .pop         (pop),
      .rsp         (rsp)
   );

   // Result fields straight from the engine's output register
   assign rsp_reloc_valid = rsp.reloc_valid;
   assign rsp_offset      = rsp.offset;
   assign rsp_segment     = rsp.segment;
   assign rsp_last        = rsp.last;
   assign rsp_error       = rsp.error;

endmodule
`default_nettype wire
